/* design/lkc_pkg.sv */
// Package for the keyed statement cache: sizes, command codes, request and result types, byte mask.
// No dependencies.
`default_nettype none
package lkc_pkg;
	localparam int SLOTS_DEF = 16;
	localparam int TEXT_MAX_DEF = 4096;
	localparam int NAME_BYTES_DEF = 8;

	typedef enum logic [1:0] {
		CMD_PARSE = 2'd0,
		CMD_BIND = 2'd1,
		CMD_CLOSE_STMT = 2'd2,
		CMD_CLOSE_PORTAL = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic [63:0] name_key;
		logic [7:0] name_size;
		logic name_complete;
		logic [31:0] text_handle;
		logic [15:0] text_size;
		logic query_complete;
		logic body_truncated;
	} req_t;

	typedef struct packed {
		logic hit;
		logic [3:0] slot;
		logic [31:0] generation;
		logic truncated;
		logic evicted;
		logic [31:0] stored_text_handle;
		logic [12:0] stored_text_len;
		logic [4:0] occupancy;
		logic [31:0] eviction_count;
	} rsp_t;

	function automatic logic [63:0] byte_mask(input logic [7:0] nbytes);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++)
			if (nbytes > 8'(i)) m[i*8 +: 8] = 8'hff;
		return m;
	endfunction
endpackage
`default_nettype wire

/* design/lkc_if.sv */
// Valid/ready channel interface carrying one payload of type T.
// No dependencies; the payload type is set by the parameter T.
`default_nettype none
interface lkc_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* design/lkc_queue.sv */
// Two-entry request queue between the front and back parts.
// Depends on lkc_pkg.
`default_nettype none
module lkc_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire lkc_pkg::req_t in_data,
	input wire logic in_valid,
	output logic in_ready,
	output lkc_pkg::req_t out_data,
	output logic out_valid,
	input wire logic out_ready
);
	import lkc_pkg::*;
	req_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

/* design/lkc_back.sv */
// Back part: match, victim search, table update and result register.
// Depends on lkc_pkg.
`default_nettype none
module lkc_back #(
	parameter int SLOTS = lkc_pkg::SLOTS_DEF,
	parameter int TEXT_MAX = lkc_pkg::TEXT_MAX_DEF,
	parameter int NAME_BYTES = lkc_pkg::NAME_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire lkc_pkg::req_t req,
	input wire logic req_valid,
	output logic req_ready,
	output lkc_pkg::rsp_t rsp,
	output logic rsp_valid,
	input wire logic rsp_ready
);
	import lkc_pkg::*;
	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_UPDATE} state_t;

	logic [SLOTS-1:0] used_q;
	logic [63:0] key_q [SLOTS];
	logic [7:0] nlen_q [SLOTS];
	logic [31:0] ref_q [SLOTS];
	logic [12:0] tlen_q [SLOTS];
	logic [SLOTS-1:0] trunc_q;
	logic [31:0] gen_q [SLOTS];
	logic [63:0] stamp_q [SLOTS];
	logic [63:0] use_clock_q;
	logic [CW-1:0] used_cnt_q;
	logic [31:0] evict_cnt_q;

	state_t state_q;
	req_t cur_q;
	logic found_q;
	logic [IW-1:0] match_q;
	logic free_found_q;
	logic [IW-1:0] free_q;
	logic [IW-1:0] lru_q;
	logic [IW:0] scan_q;

	// one slot compared per cycle during the search
	logic [63:0] mask_c;
	logic [IW-1:0] si;
	logic hit_c;
	assign mask_c = byte_mask(cur_q.name_size);
	assign si = scan_q[IW-1:0];
	assign hit_c = used_q[si] && nlen_q[si] == cur_q.name_size
		&& ((key_q[si] & mask_c) == (cur_q.name_key & mask_c));

	logic [7:0] n_c;
	assign n_c = (cur_q.name_size < 8'(NAME_BYTES)) ? cur_q.name_size : 8'(NAME_BYTES);
	logic [12:0] tl_c;
	assign tl_c = (32'(cur_q.text_size) < 32'(TEXT_MAX)) ? 13'(cur_q.text_size) : 13'(TEXT_MAX);

	logic is_parse_c, is_bind_c, is_close_c, trunc_c;
	assign is_parse_c = cur_q.command == CMD_PARSE && cur_q.name_complete;
	assign is_bind_c = cur_q.command == CMD_BIND && found_q;
	assign is_close_c = cur_q.command == CMD_CLOSE_STMT && cur_q.name_complete && found_q;
	assign trunc_c = !cur_q.query_complete || cur_q.body_truncated;

	// target slot, eviction and result for the update cycle
	logic [IW-1:0] sel_c;
	logic ev_c;
	logic [CW-1:0] uc_c;
	rsp_t rsp_c;
	always_comb begin
		sel_c = match_q;
		ev_c = 1'b0;
		uc_c = used_cnt_q;
		if (is_parse_c && !found_q) begin
			if (free_found_q) begin
				sel_c = free_q;
				uc_c = used_cnt_q + CW'(1);
			end else begin
				sel_c = lru_q;
				ev_c = 1'b1;
			end
		end else if (is_close_c) begin
			uc_c = used_cnt_q - CW'(1);
		end
		rsp_c = '0;
		rsp_c.occupancy = 5'(uc_c);
		rsp_c.eviction_count = evict_cnt_q + 32'(ev_c);
		if (is_parse_c) begin
			rsp_c.hit = 1'b1;
			rsp_c.slot = 4'(sel_c);
			rsp_c.generation = gen_q[sel_c] + 32'd1;
			rsp_c.truncated = trunc_c;
			rsp_c.evicted = ev_c;
			rsp_c.stored_text_handle = cur_q.text_handle;
			rsp_c.stored_text_len = tl_c;
		end else if (is_bind_c) begin
			rsp_c.hit = 1'b1;
			rsp_c.slot = 4'(sel_c);
			rsp_c.generation = gen_q[sel_c];
			rsp_c.truncated = trunc_q[sel_c];
			rsp_c.stored_text_handle = ref_q[sel_c];
			rsp_c.stored_text_len = tlen_q[sel_c];
		end else if (is_close_c) begin
			rsp_c.hit = 1'b1;
			rsp_c.slot = 4'(sel_c);
			rsp_c.generation = gen_q[sel_c] + 32'd1;
			rsp_c.truncated = trunc_q[sel_c];
			rsp_c.stored_text_handle = ref_q[sel_c];
		end
	end

	assign req_ready = (state_q == ST_IDLE) && !rsp_valid;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid && req_ready) cur_q <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rsp_valid <= 1'b0;
			rsp <= '0;
			used_q <= '0;
			trunc_q <= '0;
			use_clock_q <= '0;
			used_cnt_q <= '0;
			evict_cnt_q <= '0;
			found_q <= 1'b0;
			free_found_q <= 1'b0;
			match_q <= '0;
			free_q <= '0;
			lru_q <= '0;
			scan_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				key_q[i] <= '0;
				nlen_q[i] <= '0;
				tlen_q[i] <= '0;
				gen_q[i] <= '0;
				stamp_q[i] <= '0;
			end
		end else begin
			if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (req_valid && req_ready) begin
						state_q <= ST_SEARCH;
						scan_q <= '0;
						found_q <= 1'b0;
						free_found_q <= 1'b0;
						lru_q <= '0;
					end
				end
				ST_SEARCH: begin
					if (hit_c && !found_q) begin
						found_q <= 1'b1;
						match_q <= si;
					end
					if (!used_q[si] && !free_found_q) begin
						free_found_q <= 1'b1;
						free_q <= si;
					end
					if (stamp_q[si] < stamp_q[lru_q]) lru_q <= si;
					if (scan_q == (IW+1)'(SLOTS - 1)) state_q <= ST_UPDATE;
					else scan_q <= scan_q + (IW+1)'(1);
				end
				ST_UPDATE: begin
					state_q <= ST_IDLE;
					rsp_valid <= 1'b1;
					rsp <= rsp_c;
					used_cnt_q <= uc_c;
					evict_cnt_q <= rsp_c.eviction_count;
					if (is_parse_c) begin
						use_clock_q <= use_clock_q + 64'd1;
						used_q[sel_c] <= 1'b1;
						trunc_q[sel_c] <= trunc_c;
						gen_q[sel_c] <= gen_q[sel_c] + 32'd1;
						stamp_q[sel_c] <= use_clock_q + 64'd1;
						key_q[sel_c] <= cur_q.name_key & byte_mask(n_c);
						nlen_q[sel_c] <= n_c;
						tlen_q[sel_c] <= tl_c;
					end else if (is_bind_c) begin
						use_clock_q <= use_clock_q + 64'd1;
						stamp_q[sel_c] <= use_clock_q + 64'd1;
					end else if (is_close_c) begin
						used_q[sel_c] <= 1'b0;
						gen_q[sel_c] <= gen_q[sel_c] + 32'd1;
						nlen_q[sel_c] <= '0;
						key_q[sel_c] <= '0;
						tlen_q[sel_c] <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// text references are kept across a close and read only once written
	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE && is_parse_c) ref_q[sel_c] <= cur_q.text_handle;
	end
endmodule
`default_nettype wire

/* design/lru_keyed_statement_cache.sv */
// Keyed statement cache, LRU replacement, fully associative over SLOTS entries.
// Channels: req (sink) carries commands, rsp (source) carries one result per command.
// Every accepted command yields exactly one result, in order.
// The front part registers commands into a two-entry queue; the back part
// scans the table one slot per cycle, then updates and registers the result.
// The back part holds one command at a time and takes the next only once it is
// idle and its result register has been cleared, so the slot scan and the wait
// for the result to clear set the sustained throughput.
// The queue keeps accepting while a result waits, until two commands are held.
// Reset (arst_n low) empties the table, clears counters and stamps.
// A stalled receiver holds the result; the back part waits, the queue fills.
// Depends on lkc_pkg, lkc_if, lkc_queue, lkc_back.
`default_nettype none
module lru_keyed_statement_cache #(
	parameter int SLOTS = lkc_pkg::SLOTS_DEF,
	parameter int TEXT_MAX = lkc_pkg::TEXT_MAX_DEF,
	parameter int NAME_BYTES = lkc_pkg::NAME_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	lkc_if.sink req,
	lkc_if.source rsp
);
	import lkc_pkg::*;
	req_t q_data;
	logic q_valid, q_ready;
	rsp_t r_data;

	lkc_queue u_queue (
		.clk, .arst_n,
		.in_data(req.payload), .in_valid(req.valid), .in_ready(req.ready),
		.out_data(q_data), .out_valid(q_valid), .out_ready(q_ready)
	);

	lkc_back #(.SLOTS(SLOTS), .TEXT_MAX(TEXT_MAX), .NAME_BYTES(NAME_BYTES)) u_back (
		.clk, .arst_n,
		.req(q_data), .req_valid(q_valid), .req_ready(q_ready),
		.rsp(r_data), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready)
	);
	assign rsp.payload = r_data;

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> r_data.occupancy <= 5'(SLOTS)) else $error("occupancy too big");
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid) else $error("result dropped");
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && r_data.evicted |-> r_data.occupancy == 5'(SLOTS))
		else $error("eviction with free slot");
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking bench for the keyed statement cache: a request driver, a result monitor
// and a table predictor with LRU replacement. Depends on lkc_pkg, lkc_if and the block.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lkc_pkg::*;

	localparam int NSLOT = 16;
	localparam int TMAX = 4096;
	localparam int NBYTES = 8;
	localparam int LATENCY = NSLOT + 3;
	localparam int WATCH_LIMIT = 20000;

	logic clk;
	logic arst_n;
	lkc_if #(.T(req_t)) req ();
	lkc_if #(.T(rsp_t)) rsp ();

	lru_keyed_statement_cache dut (.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source));

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// predicted table
	logic [NSLOT-1:0] t_used;
	logic [63:0] t_key [NSLOT];
	logic [7:0] t_nlen [NSLOT];
	logic [31:0] t_ref [NSLOT];
	logic [12:0] t_tlen [NSLOT];
	logic t_trunc [NSLOT];
	logic [31:0] t_gen [NSLOT];
	logic [63:0] t_stamp [NSLOT];
	logic [63:0] use_tick;
	logic [4:0] live_count;
	logic [31:0] evict_total;

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];
	int send_idle_pct, recv_stall_pct;
	int hold_cycles;
	bit fails;
	int quiet_cycles;

	function automatic logic [63:0] low_bytes(input int n);
		if (n >= 8) return '1;
		return (64'd1 << (8 * n)) - 64'd1;
	endfunction

	function automatic int lookup(input logic [63:0] k, input logic [7:0] l);
		logic [63:0] m;
		m = low_bytes(l);
		for (int i = 0; i < NSLOT; i++)
			if (t_used[i] && t_nlen[i] == l && (t_key[i] & m) == (k & m)) return i;
		return -1;
	endfunction

	function automatic rsp_t cache_apply(input req_t r);
		rsp_t o;
		int s;
		bit ev;
		int n;
		o = '0;
		s = -1;
		ev = 0;
		if (r.command == CMD_PARSE && r.name_complete) begin
			s = lookup(r.name_key, r.name_size);
			if (s < 0) begin
				for (int i = 0; i < NSLOT; i++)
					if (!t_used[i] && s < 0) s = i;
				if (s >= 0) live_count++;
				else begin
					s = 0;
					for (int i = 1; i < NSLOT; i++)
						if (t_stamp[i] < t_stamp[s]) s = i;
					evict_total++;
					ev = 1;
				end
			end
			n = r.name_size < NBYTES ? r.name_size : NBYTES;
			use_tick++;
			t_used[s] = 1'b1;
			t_trunc[s] = !r.query_complete || r.body_truncated;
			t_gen[s]++;
			t_stamp[s] = use_tick;
			t_key[s] = r.name_key & low_bytes(n);
			t_nlen[s] = 8'(n);
			t_ref[s] = r.text_handle;
			t_tlen[s] = r.text_size < TMAX ? 13'(r.text_size) : 13'(TMAX);
		end else if (r.command == CMD_BIND) begin
			s = lookup(r.name_key, r.name_size);
			if (s >= 0) begin
				use_tick++;
				t_stamp[s] = use_tick;
			end
		end else if (r.command == CMD_CLOSE_STMT && r.name_complete) begin
			s = lookup(r.name_key, r.name_size);
			if (s >= 0) begin
				t_used[s] = 1'b0;
				t_gen[s]++;
				t_nlen[s] = '0;
				t_key[s] = '0;
				t_tlen[s] = '0;
				live_count--;
			end
		end
		if (s >= 0) begin
			o.hit = 1'b1;
			o.slot = 4'(s);
			o.generation = t_gen[s];
			o.truncated = t_trunc[s];
			o.evicted = ev;
			o.stored_text_handle = t_ref[s];
			o.stored_text_len = t_tlen[s];
		end
		o.occupancy = live_count;
		o.eviction_count = evict_total;
		return o;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.payload <= '0;
		end else if (!req.valid || req.ready) begin
			if (req.valid) expected_rsps.push_back(cache_apply(req.payload));
			if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				req.valid <= 1'b1;
				req.payload <= pending_reqs.pop_front();
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_rsps.size() == 0) begin
					$error("result with no request outstanding");
					fails = 1;
				end else begin
					rsp_t e;
					e = expected_rsps.pop_front();
					if (e.hit != rsp.payload.hit) begin
						$error("hit exp %0h got %0h", e.hit, rsp.payload.hit); fails = 1; end
					if (e.slot != rsp.payload.slot) begin
						$error("slot exp %0h got %0h", e.slot, rsp.payload.slot); fails = 1; end
					if (e.generation != rsp.payload.generation) begin
						$error("generation exp %0h got %0h", e.generation,
							rsp.payload.generation); fails = 1; end
					if (e.truncated != rsp.payload.truncated) begin
						$error("truncated exp %0h got %0h", e.truncated,
							rsp.payload.truncated); fails = 1; end
					if (e.evicted != rsp.payload.evicted) begin
						$error("evicted exp %0h got %0h", e.evicted,
							rsp.payload.evicted); fails = 1; end
					if (e.stored_text_handle != rsp.payload.stored_text_handle) begin
						$error("stored_text_handle exp %0h got %0h", e.stored_text_handle,
							rsp.payload.stored_text_handle); fails = 1; end
					if (e.stored_text_len != rsp.payload.stored_text_len) begin
						$error("stored_text_len exp %0h got %0h", e.stored_text_len,
							rsp.payload.stored_text_len); fails = 1; end
					if (e.occupancy != rsp.payload.occupancy) begin
						$error("occupancy exp %0h got %0h", e.occupancy,
							rsp.payload.occupancy); fails = 1; end
					if (e.eviction_count != rsp.payload.eviction_count) begin
						$error("eviction_count exp %0h got %0h", e.eviction_count,
							rsp.payload.eviction_count); fails = 1; end
				end
			end
			// long hold-off counted here, then normal random stalls
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready) || hold_cycles > 0)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic req_t make_req(input cmd_t c, input logic [63:0] k, input logic [7:0] l,
		input bit full);
		req_t r;
		r.command = c;
		r.name_key = k;
		r.name_size = l;
		r.name_complete = full;
		r.text_handle = $urandom;
		r.text_size = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(TMAX + 2));
		r.query_complete = 1'($urandom_range(1));
		r.body_truncated = 1'($urandom_range(1));
		return r;
	endfunction

	// names drawn from a small pool so that binds and closes hit
	function automatic req_t rand_req();
		logic [7:0] l;
		logic [63:0] k;
		int p;
		cmd_t c;
		p = $urandom_range(99);
		if (p < 45) c = CMD_PARSE;
		else if (p < 75) c = CMD_BIND;
		else if (p < 95) c = CMD_CLOSE_STMT;
		else c = CMD_CLOSE_PORTAL;
		if ($urandom_range(9) == 0) begin
			l = 8'($urandom);
			k = {$urandom, $urandom};
		end else begin
			l = 8'($urandom_range(8));
			k = {$urandom, $urandom} & low_bytes(l);
			if ($urandom_range(3) != 0) k = 64'($urandom_range(23)) & low_bytes(l);
		end
		return make_req(c, k, l, $urandom_range(15) != 0);
	endfunction

	task automatic wait_drain();
		while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		logic [63:0] xk;
		arst_n = 1'b0;
		fails = 0;
		hold_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		t_used = '0;
		for (int i = 0; i < NSLOT; i++) begin
			t_key[i] = '0; t_nlen[i] = '0; t_ref[i] = '0; t_tlen[i] = '0;
			t_trunc[i] = 1'b0; t_gen[i] = '0; t_stamp[i] = '0;
		end
		use_tick = '0;
		live_count = '0;
		evict_total = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, every command, unnamed, overlong, incomplete
		xk = '1;
		pending_reqs.push_back(make_req(CMD_BIND, 64'd0, 8'd0, 1'b1));
		pending_reqs.push_back(make_req(CMD_PARSE, 64'd0, 8'd0, 1'b1));
		pending_reqs.push_back(make_req(CMD_BIND, 64'd0, 8'd0, 1'b1));
		pending_reqs.push_back(make_req(CMD_PARSE, xk, 8'd255, 1'b1));
		pending_reqs.push_back(make_req(CMD_BIND, xk, 8'd255, 1'b1));
		pending_reqs.push_back(make_req(CMD_PARSE, xk, 8'd8, 1'b0));
		pending_reqs.push_back(make_req(CMD_PARSE, xk, 8'd8, 1'b1));
		pending_reqs.push_back(make_req(CMD_PARSE, xk, 8'd8, 1'b1));
		pending_reqs.push_back(make_req(CMD_CLOSE_PORTAL, xk, 8'd8, 1'b1));
		pending_reqs.push_back(make_req(CMD_CLOSE_STMT, xk, 8'd8, 1'b0));
		pending_reqs.push_back(make_req(CMD_CLOSE_STMT, xk, 8'd8, 1'b1));
		pending_reqs.push_back(make_req(CMD_CLOSE_STMT, xk, 8'd8, 1'b1));
		// fill the table past capacity to force evictions
		for (int i = 1; i <= 19; i++)
			pending_reqs.push_back(make_req(CMD_PARSE, 64'(i), 8'd1, 1'b1));
		wait_drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 9 : 64) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 9 : 64) : 0;
			if (ph == 0) hold_cycles = 300;
			for (int i = 0; i < 170; i++) pending_reqs.push_back(rand_req());
			wait_drain();
		end

		repeat (LATENCY * 2) @(posedge clk);
		if (!fails) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
`default_nettype wire
